[rtl/fpba_pkg.sv]
package fpba_pkg;

    // Table geometry
    localparam int BLOCKS    = 16;
    localparam int SIZE_BITS = 16;
    localparam int IDX_W     = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
    localparam int CNT_W     = $clog2(BLOCKS + 1);

    // Fixed field widths
    localparam int BIDX_W  = 4;
    localparam int AMT_W   = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 5;

    typedef logic [IDX_W-1:0]     addr_t;
    typedef logic [CNT_W-1:0]     cnt_t;
    typedef logic [SIZE_BITS-1:0] size_t;
    typedef logic [1:0]           policy_t;

    // Fit policy codes; the unused code behaves as first fit
    localparam policy_t POL_FIRST = 2'd0;
    localparam policy_t POL_BEST  = 2'd1;
    localparam policy_t POL_WORST = 2'd2;

    // Command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_REQ  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_BLOCKS = 4'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              cmd;
        logic [BIDX_W-1:0] block_index;
        logic [AMT_W-1:0]  amount;
    } item_t;

    typedef struct packed {
        logic              granted;
        logic [BIDX_W-1:0] chosen_block;
        logic [AMT_W-1:0]  size_left;
    } res_t;

    // Candidate decision for one scanned entry
    typedef struct packed {
        logic take;
        logic stop;
    } pick_t;

endpackage

[rtl/fpba_pick.sv]
module fpba_pick (
    input  fpba_pkg::policy_t policy,
    input  fpba_pkg::size_t   cand_size,
    input  fpba_pkg::size_t   req_size,
    input  logic              found,
    input  fpba_pkg::size_t   pick_size,
    output fpba_pkg::pick_t   pick
);

    logic fits;
    logic is_best;
    logic is_worst;
    logic better;

    // Policy compare for one entry against the current candidate
    always_comb
    begin
        fits     = (cand_size >= req_size);
        is_best  = (policy == fpba_pkg::POL_BEST);
        is_worst = (policy == fpba_pkg::POL_WORST);
        better   = (is_best && (cand_size < pick_size)) ||
                   (is_worst && (cand_size > pick_size));
        pick.take = fits && (!found || better);
        // first fit (and the spare code) ends on the first fitting entry
        pick.stop = fits && !is_best && !is_worst;
    end

endmodule

[rtl/fpba_ctrl.sv]
module fpba_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  fpba_pkg::item_t   in_item,
    input  fpba_pkg::policy_t policy,
    input  fpba_pkg::cnt_t    limit,
    output logic              res_valid,
    input  logic              res_ready,
    output fpba_pkg::res_t    res
);

    // Remaining-size table, one read and one write port
    fpba_pkg::size_t mem [fpba_pkg::BLOCKS];
    fpba_pkg::size_t rd_data_reg;
    fpba_pkg::addr_t rd_addr;
    logic            wr_en;
    fpba_pkg::addr_t wr_addr;
    fpba_pkg::size_t wr_data;

    fpba_pkg::state_t state_reg, state_next;
    fpba_pkg::addr_t  eval_idx_reg, eval_idx_next;
    fpba_pkg::cnt_t   limit_reg, limit_next;
    fpba_pkg::size_t  amt_reg, amt_next;
    logic             found_reg, found_next;
    fpba_pkg::addr_t  pick_idx_reg, pick_idx_next;
    fpba_pkg::size_t  pick_size_reg, pick_size_next;
    fpba_pkg::policy_t policy_reg, policy_next;

    fpba_pkg::pick_t  pick;
    fpba_pkg::size_t  in_amt;
    fpba_pkg::size_t  left;
    logic             accept;
    logic             last_entry;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    fpba_pick u_pick (
        .policy    (policy_reg),
        .cand_size (rd_data_reg),
        .req_size  (amt_reg),
        .found     (found_reg),
        .pick_size (pick_size_reg),
        .pick      (pick)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fpba_pkg::ST_IDLE;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        eval_idx_reg  <= eval_idx_next;
        limit_reg     <= limit_next;
        amt_reg       <= amt_next;
        pick_idx_reg  <= pick_idx_next;
        pick_size_reg <= pick_size_next;
        policy_reg    <= policy_next;
    end

    // Sequencer: accept, scan one entry per cycle, write back and report
    always_comb
    begin
        state_next     = state_reg;
        eval_idx_next  = eval_idx_reg;
        limit_next     = limit_reg;
        amt_next       = amt_reg;
        found_next     = found_reg;
        pick_idx_next  = pick_idx_reg;
        pick_size_next = pick_size_reg;
        policy_next    = policy_reg;

        in_ready   = 1'b0;
        res_valid  = 1'b0;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_addr    = fpba_pkg::IDX_W'(in_item.block_index);
        in_amt     = fpba_pkg::SIZE_BITS'(in_item.amount);
        wr_data    = in_amt;
        left       = pick_size_reg - amt_reg;
        accept     = 1'b0;
        last_entry = ((fpba_pkg::CNT_W'(eval_idx_reg) + 1'b1) == limit_reg);

        res.granted      = found_reg;
        res.chosen_block = found_reg ? fpba_pkg::BIDX_W'(pick_idx_reg) : '0;
        res.size_left    = found_reg ? fpba_pkg::AMT_W'(left) : '0;

        unique case (state_reg)
            fpba_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                accept   = in_valid;
                if (accept && (in_item.cmd == fpba_pkg::CMD_LOAD))
                begin
                    // loads beyond the table are dropped
                    wr_en = (32'(in_item.block_index) < fpba_pkg::BLOCKS);
                end
                else if (accept)
                begin
                    amt_next      = in_amt;
                    limit_next    = limit;
                    policy_next   = policy;
                    found_next    = 1'b0;
                    eval_idx_next = '0;
                    state_next    = (limit == '0) ? fpba_pkg::ST_DONE
                                                  : fpba_pkg::ST_SCAN;
                end
            end

            fpba_pkg::ST_SCAN:
            begin
                rd_addr = eval_idx_reg + 1'b1;
                if (pick.take)
                begin
                    found_next     = 1'b1;
                    pick_idx_next  = eval_idx_reg;
                    pick_size_next = rd_data_reg;
                end
                eval_idx_next = eval_idx_reg + 1'b1;
                if (pick.stop || last_entry)
                begin
                    state_next = fpba_pkg::ST_DONE;
                end
            end

            fpba_pkg::ST_DONE:
            begin
                // hold until the output register can take the result
                if (res_ready)
                begin
                    res_valid  = 1'b1;
                    wr_en      = found_reg;
                    wr_addr    = pick_idx_reg;
                    wr_data    = left;
                    state_next = fpba_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = fpba_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/fit_policy_block_allocator.sv]
// Fit-policy block allocator. Holds the remaining size of 16 memory blocks in
// a table with one read and one write port. A load beat (tuser = 0) writes one
// block size and returns nothing. A request beat (tuser = 1) scans blocks
// 0 .. min(num_blocks, 16) - 1, one table read per cycle, then writes the
// reduced size back and returns one result; first fit stops at the first
// fitting block. The result sits in an output register so the next beat
// can be taken while it waits. Policy 0 is first fit, 1 best fit, 2 worst fit
// (3 acts as first fit); ties go to the lowest index. The table is not
// cleared at reset: load every block before requesting from it.
module fit_policy_block_allocator (
    input  logic        clk,
    input  logic        rst_n,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [4:0]  cfg_data,
    // input beats
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [3:0] block_index, [19:4] amount, [23:20] zero
    input  logic        s_tuser,   // [0] cmd
    // result beats
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [3:0] chosen_block, [19:4] size_left, [23:20] zero
    output logic        m_tuser    // [0] granted
);

    fpba_pkg::policy_t fit_policy_reg;
    logic [4:0]        num_blocks_reg;
    fpba_pkg::cnt_t    limit;

    fpba_pkg::item_t   in_item;
    fpba_pkg::res_t    res;
    logic              res_valid;
    logic              res_ready;

    logic              out_valid_reg;
    fpba_pkg::res_t    out_reg;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_policy_reg <= fpba_pkg::POL_FIRST;
            num_blocks_reg <= 5'd16;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == fpba_pkg::CFG_FIT_POLICY)
            begin
                fit_policy_reg <= cfg_data[1:0];
            end
            else if (cfg_index == fpba_pkg::CFG_NUM_BLOCKS)
            begin
                num_blocks_reg <= cfg_data;
            end
        end
    end

    // Clamp the searched range to the table depth
    always_comb
    begin
        if (32'(num_blocks_reg) > fpba_pkg::BLOCKS)
        begin
            limit = fpba_pkg::CNT_W'(fpba_pkg::BLOCKS);
        end
        else
        begin
            limit = fpba_pkg::CNT_W'(num_blocks_reg);
        end
    end

    assign in_item.cmd         = s_tuser;
    assign in_item.block_index = s_tdata[3:0];
    assign in_item.amount      = s_tdata[19:4];

    fpba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .policy    (fit_policy_reg),
        .limit     (limit),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Output register
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.granted;
    assign m_tdata  = {4'd0, out_reg.size_left, out_reg.chosen_block};

`ifndef NO_ASSERTIONS
    // A refused request reports zero block and size
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == 24'd0))
        else $error("not-granted result carries nonzero fields");

    // A grant names a block inside the searched range
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (32'(m_tdata[3:0]) < 32'(num_blocks_reg)))
        else $error("granted block outside searched range");

    // No input beat is taken while a result is being handed over
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !s_tready)
        else $error("input accepted during result hand-off");

    // A result is only produced when the output register has room
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |-> !res_valid)
        else $error("result overwrote a waiting beat");
`endif

endmodule

[tb/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int MAX_REPORTS    = 10;

    // DUT ports; every input has a known value from time zero
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [3:0]  cfg_index = '0;
    logic [4:0]  cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;   // [3:0] block_index, [19:4] amount, [23:20] zero
    logic        s_tuser   = 1'b0; // [0] cmd
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;          // [3:0] chosen_block, [19:4] size_left, [23:20] zero
    logic        m_tuser;          // [0] granted

    fit_policy_block_allocator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Clock: 10 ns period
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 0;
    end

    // Shadow of the allocator: remaining sizes and register copies
    fpba_pkg::size_t   blk_left [fpba_pkg::BLOCKS];
    fpba_pkg::policy_t mdl_policy = fpba_pkg::POL_FIRST;
    logic [4:0]        mdl_count  = 5'd16;

    fpba_pkg::item_t alloc_beats [$];   // beats waiting to be sent
    fpba_pkg::res_t  grant_queue [$];   // predicted grant beats, oldest first

    fpba_pkg::item_t drv_item;
    fpba_pkg::res_t  drv_grant;
    fpba_pkg::res_t  seen_grant;
    fpba_pkg::res_t  want_grant;
    int    send_gap   = 0;
    int    stall_left = 0;
    bit    steady     = 1'b0;   // phase without any idling
    int    idle_cycles = 0;

    int n_loads    = 0;
    int n_requests = 0;
    int n_granted  = 0;
    int n_denied   = 0;
    int n_cfg      = 0;
    int n_phases   = 0;
    int n_errors   = 0;

    // Gap length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Apply one beat to the shadow table; returns 1 when a grant beat follows
    function automatic bit predict_alloc(input fpba_pkg::item_t it,
                                         output fpba_pkg::res_t r);
        int  lim;
        int  pick;
        bit  found;
        r     = '0;
        pick  = 0;
        found = 1'b0;
        if (it.cmd == fpba_pkg::CMD_LOAD)
        begin
            blk_left[it.block_index] = it.amount;
            n_loads++;
            return 1'b0;
        end
        n_requests++;
        lim = (mdl_count > fpba_pkg::BLOCKS) ? fpba_pkg::BLOCKS : int'(mdl_count);
        for (int j = 0; j < lim; j++)
        begin
            if (blk_left[j] >= it.amount)
            begin
                if (!found)
                begin
                    found = 1'b1;
                    pick  = j;
                end
                else if (mdl_policy == fpba_pkg::POL_BEST && blk_left[j] < blk_left[pick])
                    pick = j;
                else if (mdl_policy == fpba_pkg::POL_WORST && blk_left[j] > blk_left[pick])
                    pick = j;
            end
        end
        if (found)
        begin
            blk_left[pick] = blk_left[pick] - it.amount;
            r.granted      = 1'b1;
            r.chosen_block = pick[fpba_pkg::BIDX_W-1:0];
            r.size_left    = blk_left[pick];
        end
        return 1'b1;
    endfunction

    function automatic void flag_mismatch(input string what, input int unsigned want,
                                          input int unsigned got);
        n_errors++;
        if (n_errors <= MAX_REPORTS)
            $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
    endfunction

    // Input driver: presents queued beats, random gaps between them
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                if (predict_alloc(drv_item, drv_grant))
                    grant_queue.push_back(drv_grant);
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0 && !steady)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (alloc_beats.size() > 0)
                begin
                    drv_item = alloc_beats.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {4'b0000, drv_item.amount, drv_item.block_index};
                    s_tuser  <= drv_item.cmd;
                    send_gap = steady ? 0 : pick_gap();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Result monitor: random back-pressure, compares each beat with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                seen_grant.granted      = m_tuser;
                seen_grant.chosen_block = m_tdata[3:0];
                seen_grant.size_left    = m_tdata[19:4];
                if (grant_queue.size() == 0)
                begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("[%0t] result beat with nothing pending: granted %0d block %0d left %0d",
                                 $realtime, seen_grant.granted, seen_grant.chosen_block,
                                 seen_grant.size_left);
                end
                else
                begin
                    want_grant = grant_queue.pop_front();
                    if (want_grant.granted)
                        n_granted++;
                    else
                        n_denied++;
                    if (seen_grant.granted !== want_grant.granted)
                        flag_mismatch("granted", want_grant.granted, seen_grant.granted);
                    if (seen_grant.chosen_block !== want_grant.chosen_block)
                        flag_mismatch("chosen_block", want_grant.chosen_block,
                                      seen_grant.chosen_block);
                    if (seen_grant.size_left !== want_grant.size_left)
                        flag_mismatch("size_left", want_grant.size_left, seen_grant.size_left);
                    if (m_tdata[23:20] !== 4'b0000)
                        flag_mismatch("tdata padding", 0, m_tdata[23:20]);
                end
            end
            if (steady)
                m_tready <= 1'b1;
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if ($urandom_range(0, 99) < 15)
            begin
                stall_left = pick_gap();
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Watchdog: too many cycles without any beat ends the run
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles, %0d grants still pending",
                         idle_cycles, grant_queue.size());
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic queue_beat(input logic cmd, input logic [3:0] idx, input logic [15:0] amt);
        fpba_pkg::item_t it;
        it.cmd         = cmd;
        it.block_index = idx;
        it.amount      = amt;
        alloc_beats.push_back(it);
    endtask

    // Register write; the shadow copy follows at the accepting edge
    task automatic cfg_write(input logic [3:0] idx, input logic [4:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == fpba_pkg::CFG_FIT_POLICY)
            mdl_policy = val[1:0];
        else if (idx == fpba_pkg::CFG_NUM_BLOCKS)
            mdl_count = val;
        n_cfg++;
        cfg_valid <= 1'b0;
    endtask

    // Wait until everything sent has been answered, then let the block settle
    task automatic wait_drained();
        do
            @(negedge clk);
        while (alloc_beats.size() != 0 || s_tvalid || grant_queue.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [15:0] rand_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 16'($urandom_range(0, 16) * 16);   // coarse sizes give ties
        if (r < 70)
            return 16'($urandom_range(0, 1000));
        if (r < 85)
            return 16'($urandom_range(0, 65535));
        if (r < 95)
            return 16'hFFFF;
        return 16'd0;
    endfunction

    function automatic logic [15:0] rand_ask();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 16'd0;
        if (r < 60)
            return 16'($urandom_range(1, 64));
        if (r < 80)
            return 16'($urandom_range(65, 600));
        if (r < 95)
            return 16'($urandom_range(0, 65535));
        return 16'hFFFF;
    endfunction

    // Mixed traffic: reloads keep blocks refilled, requests drain them
    task automatic queue_random(input int n);
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 99) < 30)
                queue_beat(fpba_pkg::CMD_LOAD, 4'($urandom_range(0, 15)), rand_size());
            else
                queue_beat(fpba_pkg::CMD_REQ, 4'($urandom_range(0, 15)), rand_ask());
        end
    endtask

    initial
    begin
        logic [15:0] init_sizes [16];
        int          ph_policy  [10];
        int          ph_count   [10];
        int          pol;
        int          cnt;

        init_sizes = '{16'd0, 16'hFFFF, 16'd100, 16'd50, 16'd100, 16'd200, 16'd50, 16'd300,
                       16'd1, 16'd2, 16'd400, 16'd50, 16'd16, 16'd32, 16'd64, 16'd128};
        ph_policy  = '{0, 1, 2, 3, 1, 2, 0, 2, 1, -1};
        ph_count   = '{16, 16, 16, 16, 5, 1, 31, 20, 8, -1};
        for (int b = 0; b < fpba_pkg::BLOCKS; b++)
            blk_left[b] = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: load every block, then first fit at reset defaults
        for (int b = 0; b < fpba_pkg::BLOCKS; b++)
            queue_beat(fpba_pkg::CMD_LOAD, 4'(b), init_sizes[b]);
        queue_beat(fpba_pkg::CMD_REQ, 4'd0, 16'd0);        // zero request
        queue_beat(fpba_pkg::CMD_REQ, 4'd15, 16'hFFFF);    // exact fit of the largest size
        queue_beat(fpba_pkg::CMD_REQ, 4'd7, 16'hFFFF);     // nothing fits any more
        queue_beat(fpba_pkg::CMD_REQ, 4'd0, 16'd60);
        queue_beat(fpba_pkg::CMD_REQ, 4'd0, 16'd50);
        wait_drained();
        n_phases++;

        // Best fit with ties; writes to unused indexes change nothing
        cfg_write(fpba_pkg::CFG_FIT_POLICY, {3'b000, fpba_pkg::POL_BEST});
        cfg_write(4'hF, 5'h1F);
        cfg_write(4'd6, 5'h0A);
        queue_beat(fpba_pkg::CMD_REQ, 4'd0, 16'd40);
        queue_beat(fpba_pkg::CMD_REQ, 4'd0, 16'd50);
        wait_drained();

        // Worst fit, then the unused policy code behaving as first fit
        cfg_write(fpba_pkg::CFG_FIT_POLICY, {3'b111, fpba_pkg::POL_WORST});
        queue_beat(fpba_pkg::CMD_REQ, 4'd0, 16'd10);
        wait_drained();
        cfg_write(fpba_pkg::CFG_FIT_POLICY, 5'b11111);
        queue_beat(fpba_pkg::CMD_REQ, 4'd0, 16'd1);
        wait_drained();

        // No blocks searched, then a count above the table size
        cfg_write(fpba_pkg::CFG_NUM_BLOCKS, 5'd0);
        queue_beat(fpba_pkg::CMD_REQ, 4'd0, 16'd0);
        queue_beat(fpba_pkg::CMD_REQ, 4'd3, 16'd5);
        wait_drained();
        cfg_write(fpba_pkg::CFG_NUM_BLOCKS, 5'd31);
        queue_beat(fpba_pkg::CMD_REQ, 4'd0, 16'd0);
        queue_beat(fpba_pkg::CMD_REQ, 4'd0, 16'hFFFF);
        wait_drained();
        n_phases++;

        // Random phases across policies and block counts
        for (int p = 0; p < 10; p++)
        begin
            pol = (ph_policy[p] < 0) ? $urandom_range(0, 3) : ph_policy[p];
            cnt = (ph_count[p] < 0) ? $urandom_range(0, 31) : ph_count[p];
            cfg_write(fpba_pkg::CFG_FIT_POLICY, {3'($urandom_range(0, 7)), 2'(pol)});
            cfg_write(fpba_pkg::CFG_NUM_BLOCKS, 5'(cnt));
            steady = ($urandom_range(0, 3) == 0);
            queue_random(60);
            wait_drained();
            steady = 1'b0;
            n_phases++;
        end

        $display("covered %0d phases, %0d register writes, %0d loads, %0d requests",
                 n_phases, n_cfg, n_loads, n_requests);
        $display("requests granted %0d, refused %0d, errors %0d",
                 n_granted, n_denied, n_errors);
        if (n_errors == 0 && grant_queue.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
